// ===== sv/trb_pkg.sv =====
// shared constants, codes and control types for the token replay buffer
package trb_pkg;

  localparam int BUFFER_DEPTH = 64;
  localparam int MARK_DEPTH   = 16;
  localparam int TOKEN_WIDTH  = 32;

  localparam int IDX_W   = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int CNT_W   = $clog2(BUFFER_DEPTH + 1);
  localparam int MIDX_W  = (MARK_DEPTH > 1) ? $clog2(MARK_DEPTH) : 1;
  localparam int MCNT_W  = $clog2(MARK_DEPTH + 1);
  localparam int OP_W    = 2;
  localparam int STAT_W  = 3;

  typedef enum logic [OP_W-1:0] {
    OP_CONSUME = 2'd0,
    OP_MARK    = 2'd1,
    OP_RESET   = 2'd2,
    OP_FLUSH   = 2'd3
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK         = 3'd0,
    ST_FULL       = 3'd1,
    ST_MARK_OVER  = 3'd2,
    ST_MARK_UNDER = 3'd3,
    ST_NO_CURSOR  = 3'd4
  } status_e;

  // sequencer commands to the datapath
  typedef struct packed {
    logic capture;
    logic exec;
    logic rd;
    logic load;
  } trb_cmd_t;

  // datapath status back to the sequencer
  typedef struct packed {
    logic out_full;
  } trb_stat_t;

endpackage

// ===== sv/trb_in_if.sv =====
// request channel: operation and scanner token
interface trb_in_if;
  logic                            valid;
  logic                            ready;
  logic [trb_pkg::OP_W-1:0]        op;
  logic [trb_pkg::TOKEN_WIDTH-1:0] new_token;

  modport source (output valid, output op, output new_token, input ready);
  modport sink   (input valid, input op, input new_token, output ready);
endinterface

// ===== sv/trb_out_if.sv =====
// result channel: current token, count and status
interface trb_out_if;
  logic                            valid;
  logic                            ready;
  logic [trb_pkg::TOKEN_WIDTH-1:0] current_token;
  logic                            token_valid;
  logic [trb_pkg::CNT_W-1:0]       entry_count;
  logic [trb_pkg::STAT_W-1:0]      status;

  modport source (output valid, output current_token, output token_valid,
                  output entry_count, output status, input ready);
  modport sink   (input valid, input current_token, input token_valid,
                  input entry_count, input status, output ready);
endinterface

// ===== sv/trb_ctrl.sv =====
// sequencer: capture, pointer update, token read, result load
module trb_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  trb_pkg::trb_stat_t stat_i,
  output trb_pkg::trb_cmd_t  cmd_o
);
  import trb_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_READ = 4'b0100,
    S_LOAD = 4'b1000
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = S_READ;
      end
      S_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = S_LOAD;
      end
      S_LOAD: begin
        // hold until the output register is free
        if (!stat_i.out_full) begin
          cmd_o.load = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== sv/trb_dp.sv =====
// datapath: ring pointers, token memory, mark stack and output register
module trb_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  trb_pkg::trb_cmd_t               cmd_i,
  output trb_pkg::trb_stat_t              stat_o,
  input  logic [trb_pkg::OP_W-1:0]        op_i,
  input  logic [trb_pkg::TOKEN_WIDTH-1:0] new_token_i,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic [trb_pkg::TOKEN_WIDTH-1:0] current_token_o,
  output logic                            token_valid_o,
  output logic [trb_pkg::CNT_W-1:0]       entry_count_o,
  output logic [trb_pkg::STAT_W-1:0]      status_o
);
  import trb_pkg::*;

  localparam logic [IDX_W:0]  DEPTH_X = (IDX_W+1)'(BUFFER_DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(BUFFER_DEPTH);
  localparam logic [MCNT_W-1:0] MDEPTH_C = MCNT_W'(MARK_DEPTH);

  typedef struct packed {
    logic [IDX_W-1:0] pos;
    logic             present;
  } mark_t;

  function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] a,
                                                input logic [IDX_W-1:0] b);
    logic [IDX_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= DEPTH_X) sum = sum - DEPTH_X;
    return sum[IDX_W-1:0];
  endfunction

  logic [TOKEN_WIDTH-1:0] token_mem [BUFFER_DEPTH];
  mark_t                  mark_q [MARK_DEPTH];

  logic [OP_W-1:0]        op_q;
  logic [TOKEN_WIDTH-1:0] tok_q;
  logic [IDX_W-1:0]       head_q, head_d;
  logic [CNT_W-1:0]       held_q, held_d;
  logic [IDX_W-1:0]       cur_q, cur_d;
  logic                   pres_q, pres_d;
  logic [MCNT_W-1:0]      depth_q, depth_d;
  status_e                status_q, status_d;
  logic [TOKEN_WIDTH-1:0] rd_data_q;

  logic                   out_valid_q;
  logic [TOKEN_WIDTH-1:0] out_tok_q;
  logic                   out_tv_q;
  logic [CNT_W-1:0]       out_cnt_q;
  logic [STAT_W-1:0]      out_st_q;

  logic                   mem_we;
  logic [IDX_W-1:0]       mem_waddr;
  logic                   mark_we;
  mark_t                  mark_wdata;
  logic [MCNT_W-1:0]      depth_dec;
  mark_t                  mark_top;
  logic [IDX_W-1:0]       rel_off;
  logic [IDX_W:0]         rel_sum;
  logic                   cur_valid;

  assign depth_dec = depth_q - 1'b1;
  assign mark_top  = mark_q[depth_dec[MIDX_W-1:0]];
  // distance of the marked ring slot from the head
  assign rel_sum   = (mark_top.pos >= head_q) ? {1'b0, mark_top.pos} - {1'b0, head_q}
                                              : {1'b0, mark_top.pos} + DEPTH_X
                                                - {1'b0, head_q};
  assign rel_off   = rel_sum[IDX_W-1:0];
  assign mem_waddr = ring_add(head_q, held_q[IDX_W-1:0]);
  assign cur_valid = pres_q && (CNT_W'(cur_q) < held_q);

  always_comb begin
    head_d     = head_q;
    held_d     = held_q;
    cur_d      = cur_q;
    pres_d     = pres_q;
    depth_d    = depth_q;
    status_d   = ST_OK;
    mem_we     = 1'b0;
    mark_we    = 1'b0;
    mark_wdata = '{pos: '0, present: pres_q};
    if (pres_q) mark_wdata.pos = ring_add(head_q, cur_q);
    unique case (op_e'(op_q))
      OP_CONSUME: begin
        if (pres_q && (CNT_W'(cur_q) + 1'b1 < held_q)) begin
          cur_d = cur_q + 1'b1;
        end else if (held_q == DEPTH_C) begin
          status_d = ST_FULL;
        end else begin
          mem_we = 1'b1;
          held_d = held_q + 1'b1;
          cur_d  = held_q[IDX_W-1:0];
          pres_d = 1'b1;
        end
      end
      OP_MARK: begin
        if (depth_q == MDEPTH_C) begin
          status_d = ST_MARK_OVER;
        end else begin
          mark_we = 1'b1;
          depth_d = depth_q + 1'b1;
        end
      end
      OP_RESET: begin
        if (depth_q == '0) begin
          status_d = ST_MARK_UNDER;
        end else begin
          depth_d = depth_dec;
          if (mark_top.present && (CNT_W'(rel_off) < held_q)) begin
            cur_d  = rel_off;
            pres_d = 1'b1;
          end else begin
            cur_d  = '0;
            pres_d = 1'b0;
          end
        end
      end
      OP_FLUSH: begin
        if (!pres_q) begin
          status_d = ST_NO_CURSOR;
        end else begin
          head_d = ring_add(head_q, cur_q);
          held_d = held_q - CNT_W'(cur_q);
          cur_d  = '0;
          if (depth_q != '0) depth_d = depth_dec;
        end
      end
      default: status_d = ST_OK;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      held_q      <= '0;
      cur_q       <= '0;
      pres_q      <= 1'b0;
      depth_q     <= '0;
      status_q    <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.exec) begin
        head_q   <= head_d;
        held_q   <= held_d;
        cur_q    <= cur_d;
        pres_q   <= pres_d;
        depth_q  <= depth_d;
        status_q <= status_d;
      end
      out_valid_q <= cmd_i.load | (out_valid_q & ~out_ready_i);
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= op_i;
      tok_q <= new_token_i;
    end
    if (cmd_i.exec && mem_we) token_mem[mem_waddr] <= tok_q;
    if (cmd_i.exec && mark_we) mark_q[depth_q[MIDX_W-1:0]] <= mark_wdata;
    if (cmd_i.rd) rd_data_q <= token_mem[ring_add(head_q, cur_q)];
    if (cmd_i.load) begin
      out_tok_q <= cur_valid ? rd_data_q : '0;
      out_tv_q  <= cur_valid;
      out_cnt_q <= held_q;
      out_st_q  <= status_q;
    end
  end

  assign stat_o.out_full = out_valid_q & ~out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign current_token_o = out_tok_q;
  assign token_valid_o   = out_tv_q;
  assign entry_count_o   = out_cnt_q;
  assign status_o        = out_st_q;

endmodule

// ===== sv/token_replay_buffer_with_marks.sv =====
// Token replay buffer with a mark stack for a backtracking parser. Each request
// (consume, mark, reset to mark, flush) is handled by a four-step sequencer:
// capture, pointer and token-store update, registered token-memory read, and
// result load. The load step waits while the output register still holds an
// untaken result, and one request is in flight at a time. The next request
// is accepted as soon as its predecessor's result is in the output register,
// even while that result still waits to be taken. No clearing pass after reset.
module token_replay_buffer_with_marks (
  input  logic clk_i,
  input  logic rst_ni,
  trb_in_if.sink    in_i,
  trb_out_if.source out_o
);
  import trb_pkg::*;

  trb_cmd_t  cmd;
  trb_stat_t stat;

  trb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  trb_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .op_i            (in_i.op),
    .new_token_i     (in_i.new_token),
    .out_ready_i     (out_o.ready),
    .out_valid_o     (out_o.valid),
    .current_token_o (out_o.current_token),
    .token_valid_o   (out_o.token_valid),
    .entry_count_o   (out_o.entry_count),
    .status_o        (out_o.status)
  );

  // one request in flight at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("request accepted while another is in flight");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.entry_count <= CNT_W'(BUFFER_DEPTH))
    else $error("entry count beyond buffer depth");

  a_no_token_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.token_valid |-> out_o.current_token == '0)
    else $error("token shown without a cursor");

  // a dropped consume can only be reported on a full buffer
  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.status == ST_FULL |-> out_o.entry_count == CNT_W'(BUFFER_DEPTH))
    else $error("full status with room left");

endmodule

// ===== bench/trb_view_checker.sv =====
// checker that predicts the buffer view for every request and compares each result
`timescale 1ns / 100ps

module trb_view_checker
  import trb_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  trb_in_if    in_mon,
  trb_out_if   out_mon,
  output int   fail_count_o,
  output int   pending_o,
  output int   checked_o
);

  typedef struct packed {
    logic [TOKEN_WIDTH-1:0] token;
    logic                   valid;
    logic [CNT_W-1:0]       count;
    status_e                status;
  } buffer_view_t;

  // predicted copy of the buffer
  logic [TOKEN_WIDTH-1:0] tok_mem [BUFFER_DEPTH];
  logic [IDX_W-1:0]       head;
  logic [CNT_W-1:0]       held;
  logic [IDX_W-1:0]       cur_off;
  logic                   cur_on;
  logic [IDX_W-1:0]       mark_pos [MARK_DEPTH];
  logic                   mark_on  [MARK_DEPTH];
  logic [MCNT_W-1:0]      depth;

  buffer_view_t expected_views[$];
  buffer_view_t want;
  int           fails;
  int           checked;
  int           errs;

  function automatic int slot(input int off);
    return (int'(head) + off) % BUFFER_DEPTH;
  endfunction

  function automatic buffer_view_t apply_request(input op_e op,
                                                 input logic [TOKEN_WIDTH-1:0] tok);
    buffer_view_t v;
    status_e      st;
    int           off;
    st = ST_OK;
    case (op)
      OP_CONSUME: begin
        if (cur_on && int'(cur_off) + 1 < int'(held)) begin
          cur_off = cur_off + 1'b1;
        end else if (int'(held) >= BUFFER_DEPTH) begin
          st = ST_FULL;
        end else begin
          tok_mem[slot(int'(held))] = tok;
          held    = held + 1'b1;
          cur_off = IDX_W'(held - 1'b1);
          cur_on  = 1'b1;
        end
      end
      OP_MARK: begin
        if (int'(depth) >= MARK_DEPTH) begin
          st = ST_MARK_OVER;
        end else begin
          mark_on[depth]  = cur_on;
          mark_pos[depth] = cur_on ? IDX_W'(slot(int'(cur_off))) : '0;
          depth = depth + 1'b1;
        end
      end
      OP_RESET: begin
        if (depth == 0) begin
          st = ST_MARK_UNDER;
        end else begin
          depth = depth - 1'b1;
          if (!mark_on[depth]) begin
            cur_on  = 1'b0;
            cur_off = '0;
          end else begin
            // ring distance from the head; outside the held tokens means flushed away
            off = (int'(mark_pos[depth]) + BUFFER_DEPTH - int'(head)) % BUFFER_DEPTH;
            if (off < int'(held)) begin
              cur_off = IDX_W'(off);
              cur_on  = 1'b1;
            end else begin
              cur_off = '0;
              cur_on  = 1'b0;
            end
          end
        end
      end
      OP_FLUSH: begin
        if (!cur_on) begin
          st = ST_NO_CURSOR;
        end else begin
          head    = IDX_W'(slot(int'(cur_off)));
          held    = held - cur_off;
          cur_off = '0;
          if (depth > 0) depth = depth - 1'b1;
        end
      end
      default: st = ST_OK;
    endcase
    v.valid  = cur_on && (cur_off < held);
    v.token  = v.valid ? tok_mem[slot(int'(cur_off))] : '0;
    v.count  = held;
    v.status = st;
    return v;
  endfunction

  task automatic report_field(input string field, input logic [TOKEN_WIDTH-1:0] want_v,
                              input logic [TOKEN_WIDTH-1:0] got_v);
    $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want_v, got_v);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head    = '0;
      held    = '0;
      cur_off = '0;
      cur_on  = 1'b0;
      depth   = '0;
      fails   = 0;
      checked = 0;
      expected_views.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
      checked_o    <= 0;
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        expected_views.push_back(apply_request(op_e'(in_mon.op), in_mon.new_token));
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_views.size() == 0) begin
          $display("%0t: result with no request waiting, expected none actual %0h/%0b/%0d/%0d",
                   $time, out_mon.current_token, out_mon.token_valid,
                   out_mon.entry_count, out_mon.status);
          fails++;
        end else begin
          want = expected_views.pop_front();
          errs = 0;
          if (out_mon.current_token !== want.token) begin
            report_field("current_token", want.token, out_mon.current_token);
            errs++;
          end
          if (out_mon.token_valid !== want.valid) begin
            report_field("token_valid", want.valid, out_mon.token_valid);
            errs++;
          end
          if (out_mon.entry_count !== want.count) begin
            report_field("entry_count", want.count, out_mon.entry_count);
            errs++;
          end
          if (out_mon.status !== want.status) begin
            report_field("status", want.status, out_mon.status);
            errs++;
          end
          if (errs != 0) fails++;
          checked++;
        end
      end
      fail_count_o <= fails;
      pending_o    <= expected_views.size();
      checked_o    <= checked;
    end
  end

endmodule

// ===== bench/tb_token_replay_buffer_with_marks.sv =====
// top of the token replay buffer bench: clock, reset, request stimulus and verdict
`timescale 1ns / 100ps

module tb_token_replay_buffer_with_marks;
  import trb_pkg::*;

  localparam int RANDOM_ITEMS = 1250;
  localparam int CYCLE_LIMIT  = 400000;

  logic clk_i;
  logic rst_ni;
  logic quiet;
  int   fail_count;
  int   pending;
  int   checked;
  int   sent;
  int   op_count [4];
  int   cycles;

  trb_in_if  in_ch ();
  trb_out_if out_ch ();

  token_replay_buffer_with_marks DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  trb_view_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("timeout after %0d cycles with %0d results outstanding", cycles, pending);
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic [TOKEN_WIDTH-1:0] rand_token();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // valid stays high across back-to-back requests, lowered only ahead of a gap
  task automatic send_request(input op_e op, input logic [TOKEN_WIDTH-1:0] tok);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.op        <= op;
    in_ch.new_token <= tok;
    do @(posedge clk_i); while (!in_ch.ready);
    op_count[int'(op)]++;
    sent++;
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // result side: random stall before each request result is taken
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
    end
  end

  initial begin
    int  kind;
    int  target;
    bit  paused;
    in_ch.valid     <= 1'b0;
    in_ch.op        <= OP_CONSUME;
    in_ch.new_token <= '0;
    rst_ni          <= 1'b0;
    quiet   = 1'b0;
    sent    = 0;
    paused  = 1'b0;
    foreach (op_count[i]) op_count[i] = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty buffer cases, cursor-less marks, flushed marks, extremes of the token
    send_request(OP_FLUSH,   32'h0000_0001);
    send_request(OP_RESET,   32'h0000_0002);
    send_request(OP_MARK,    32'h0000_0003);
    send_request(OP_CONSUME, 32'h0000_0000);
    send_request(OP_CONSUME, 32'hFFFF_FFFF);
    send_request(OP_RESET,   32'h0000_0004);
    send_request(OP_CONSUME, 32'hA5A5_A5A5);
    send_request(OP_MARK,    32'h0000_0005);
    send_request(OP_CONSUME, 32'h5A5A_5A5A);
    send_request(OP_CONSUME, 32'h0000_0001);
    send_request(OP_FLUSH,   32'h0000_0006);
    send_request(OP_FLUSH,   32'h0000_0007);
    send_request(OP_MARK,    32'h0000_0008);
    send_request(OP_CONSUME, 32'h8000_0000);
    send_request(OP_MARK,    32'h0000_0009);
    send_request(OP_FLUSH,   32'h0000_000A);
    send_request(OP_RESET,   32'h0000_000B);
    send_request(OP_CONSUME, 32'h7FFF_FFFF);
    send_request(OP_RESET,   32'h0000_000C);
    send_request(OP_MARK,    32'h0000_000D);
    send_request(OP_CONSUME, 32'h1234_5678);
    send_request(OP_RESET,   32'h0000_000E);
    send_request(OP_CONSUME, 32'hDEAD_BEEF);
    send_request(OP_FLUSH,   32'h0000_000F);

    target = sent + RANDOM_ITEMS;
    while (sent < target) begin
      quiet = ($urandom_range(0, 7) == 0);
      if (!paused && sent >= target / 2) begin
        drain_results();
        paused = 1'b1;
      end
      kind = $urandom_range(0, 39);
      if (kind == 0) begin
        // run the buffer into full, then commit
        repeat (66 + $urandom_range(0, 4)) send_request(OP_CONSUME, rand_token());
        send_request(OP_FLUSH, rand_token());
      end else if (kind <= 2) begin
        // overflow then underflow the mark stack
        repeat (17 + $urandom_range(0, 3)) send_request(OP_MARK, rand_token());
        repeat (17 + $urandom_range(0, 3)) send_request(OP_RESET, rand_token());
      end else if (kind <= 4) begin
        // keep an old mark while commits wrap the ring past its position
        send_request(OP_MARK, rand_token());
        repeat (10 + $urandom_range(0, 4)) begin
          send_request(OP_MARK, rand_token());
          repeat ($urandom_range(4, 8)) send_request(OP_CONSUME, rand_token());
          send_request(OP_FLUSH, rand_token());
        end
        send_request(OP_RESET, rand_token());
      end else if (kind <= 24) begin
        // parse attempt: mark, look ahead, then backtrack or commit
        send_request(OP_MARK, rand_token());
        repeat ($urandom_range(1, 8)) send_request(OP_CONSUME, rand_token());
        send_request($urandom_range(0, 1) ? OP_FLUSH : OP_RESET, rand_token());
      end else if (kind <= 31) begin
        // replay stored tokens after a backtrack
        send_request(OP_RESET, rand_token());
        repeat ($urandom_range(1, 6)) send_request(OP_CONSUME, rand_token());
      end else begin
        repeat ($urandom_range(1, 6)) send_request(op_e'($urandom_range(0, 3)), rand_token());
      end
    end

    quiet = 1'b0;
    drain_results();
    repeat (8) @(posedge clk_i);
    $display("covered %0d requests: %0d consume, %0d mark, %0d reset, %0d flush",
             sent, op_count[0], op_count[1], op_count[2], op_count[3]);
    $display("%0d results compared with the predicted buffer view in %0d cycles",
             checked, cycles);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
